// ===== design/vfcm_pkg.sv =====
// Package for the voxel face culling mesher: command codes, face directions,
// the voxel store entry and the request bundle passed from the top level to the sequencer.
// No dependencies.
package vfcm_pkg;

	// Command codes carried in the operation field.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_MESH  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// Face directions in emission order.
	localparam logic [2:0] DIR_NEG_Z = 3'd0;
	localparam logic [2:0] DIR_POS_Z = 3'd1;
	localparam logic [2:0] DIR_POS_Y = 3'd2;
	localparam logic [2:0] DIR_NEG_Y = 3'd3;
	localparam logic [2:0] DIR_NEG_X = 3'd4;
	localparam logic [2:0] DIR_POS_X = 3'd5;

	localparam int unsigned NUM_DIRS = 6;
	localparam int unsigned CNT_W    = 15;

	// One entry of the voxel store.
	typedef struct packed {
		logic       active;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} voxel_t;

	// Mesh request from the command decoder to the sequencer.
	typedef struct packed {
		logic       go;
		logic       restart;
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
	} mesh_req_t;

endpackage

// ===== design/vfcm_cmd_if.sv =====
// Command channel of the voxel face culling mesher: handshake and command payload.
// No dependencies.
interface vfcm_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [3:0] pos_x;
	logic [3:0] pos_y;
	logic [3:0] pos_z;
	logic       solid;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, operation, pos_x, pos_y, pos_z, solid, red_in, green_in,
		blue_in, input ready);
	modport sink (input valid, operation, pos_x, pos_y, pos_z, solid, red_in, green_in,
		blue_in, output ready);
endinterface

// ===== design/vfcm_face_if.sv =====
// Face record channel of the voxel face culling mesher: handshake and face payload.
// No dependencies.
interface vfcm_face_if;
	logic        valid;
	logic        ready;
	logic [2:0]  face_dir;
	logic [3:0]  face_x;
	logic [3:0]  face_y;
	logic [3:0]  face_z;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [16:0] base_vertex;
	logic [17:0] index_count;
	logic        last_face;

	modport source (output valid, face_dir, face_x, face_y, face_z, red_out, green_out,
		blue_out, base_vertex, index_count, last_face, input ready);
	modport sink (input valid, face_dir, face_x, face_y, face_z, red_out, green_out,
		blue_out, base_vertex, index_count, last_face, output ready);
endinterface

// ===== design/vfcm_store.sv =====
// Voxel store: one write port and one read port with registered read data.
// Depends on vfcm_pkg for the entry type.
module vfcm_store import vfcm_pkg::*; #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  voxel_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output voxel_t        rdata
);

	voxel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/vfcm_ctrl.sv =====
// Mesh sequencer: walks the voxel and its six neighbours through one shared address
// adder, gathers exposure bits, then emits one face record per exposed face.
// Depends on vfcm_pkg and vfcm_face_if.
module vfcm_ctrl import vfcm_pkg::*; #(
	parameter int unsigned CHUNK_X = 16,
	parameter int unsigned CHUNK_Y = 16,
	parameter int unsigned CHUNK_Z = 16,
	parameter int unsigned AW      = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mesh_req_t           req,
	input  logic [AW-1:0]       center,
	output logic                busy,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  voxel_t              rd_data,
	vfcm_face_if.source         face
);

	localparam logic [AW-1:0] STRIDE_X = AW'(1);
	localparam logic [AW-1:0] STRIDE_Y = AW'(CHUNK_X);
	localparam logic [AW-1:0] STRIDE_Z = AW'(CHUNK_X * CHUNK_Y);

	// Read steps: the voxel itself, then one per direction (step = direction + 1).
	localparam logic [2:0] ST_CENTER = 3'd0;
	localparam logic [2:0] ST_NEG_Z  = 3'(DIR_NEG_Z + 3'd1);
	localparam logic [2:0] ST_POS_Z  = 3'(DIR_POS_Z + 3'd1);
	localparam logic [2:0] ST_POS_Y  = 3'(DIR_POS_Y + 3'd1);
	localparam logic [2:0] ST_NEG_Y  = 3'(DIR_NEG_Y + 3'd1);
	localparam logic [2:0] ST_NEG_X  = 3'(DIR_NEG_X + 3'd1);
	localparam logic [2:0] ST_POS_X  = 3'(DIR_POS_X + 3'd1);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_DRAIN, S_EMIT} state_t;

	state_t              state_q;
	logic [2:0]          step_q;
	logic [3:0]          x_q, y_q, z_q;
	logic [AW-1:0]       center_q;
	logic [NUM_DIRS-1:0] shown_q;
	logic                active_q;
	logic [7:0]          red_q, green_q, blue_q;
	logic                rd_pend_s1;
	logic [2:0]          rd_step_s1;
	logic [CNT_W-1:0]    cnt_q;

	logic                out_valid_q;
	logic [2:0]          face_dir_q;
	logic [3:0]          face_x_q, face_y_q, face_z_q;
	logic [7:0]          red_out_q, green_out_q, blue_out_q;
	logic [16:0]         base_vertex_q;
	logic [17:0]         index_count_q;
	logic                last_face_q;

	logic [AW-1:0]       offset;
	logic                sub;
	logic                nbr_ok;
	logic                shown_dflt;
	logic [NUM_DIRS-1:0] avail;
	logic [NUM_DIRS-1:0] pick;
	logic [2:0]          pick_dir;
	logic                last;
	logic                out_free;
	logic                load_face;
	logic [CNT_W:0]      cnt_p1;
	logic [17:0]         index_next;

	// Neighbour selection for the shared address adder.
	always_comb begin
		offset = '0;
		sub    = 1'b0;
		nbr_ok = 1'b0;
		case (step_q)
			ST_CENTER: begin
				nbr_ok = 1'b1;
			end
			ST_NEG_Z: begin
				offset = STRIDE_Z;
				sub    = 1'b1;
				nbr_ok = (z_q != 4'd0);
			end
			ST_POS_Z: begin
				offset = STRIDE_Z;
				nbr_ok = (32'(z_q) + 32'd1 < CHUNK_Z);
			end
			ST_POS_Y: begin
				offset = STRIDE_Y;
				nbr_ok = (32'(y_q) + 32'd1 < CHUNK_Y);
			end
			ST_NEG_Y: begin
				offset = STRIDE_Y;
				sub    = 1'b1;
				nbr_ok = (y_q != 4'd0);
			end
			ST_NEG_X: begin
				offset = STRIDE_X;
				sub    = 1'b1;
				nbr_ok = (x_q != 4'd0);
			end
			ST_POS_X: begin
				offset = STRIDE_X;
				nbr_ok = (32'(x_q) + 32'd1 < CHUNK_X);
			end
			default: begin
				nbr_ok = 1'b0;
			end
		endcase
	end

	assign rd_addr    = sub ? (center_q - offset) : (center_q + offset);
	assign rd_en      = (state_q == S_READ) && nbr_ok;
	// Past the chunk edge the x and z faces show, the y faces do not.
	assign shown_dflt = !((step_q == ST_POS_Y) || (step_q == ST_NEG_Y));

	// Lowest exposed face still waiting.
	assign avail = shown_q & {NUM_DIRS{active_q}};
	assign pick  = avail & (~avail + NUM_DIRS'(1));
	assign last  = ((avail & ~pick) == '0);

	always_comb begin
		pick_dir = DIR_NEG_Z;
		for (int i = 0; i < NUM_DIRS; i++) begin
			if (pick[i]) begin
				pick_dir = 3'(i);
			end
		end
	end

	assign out_free   = !out_valid_q || face.ready;
	assign load_face  = (state_q == S_EMIT) && (avail != '0) && out_free;
	assign cnt_p1     = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign index_next = 18'({cnt_p1, 2'b00}) + 18'({cnt_p1, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_CENTER;
			rd_pend_s1  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			rd_step_s1 <= step_q;
			if (rd_pend_s1) begin
				if (rd_step_s1 == ST_CENTER) begin
					active_q <= rd_data.active;
					red_q    <= rd_data.red;
					green_q  <= rd_data.green;
					blue_q   <= rd_data.blue;
				end else begin
					shown_q[3'(rd_step_s1 - 3'd1)] <= !rd_data.active;
				end
			end
			if (out_valid_q && face.ready) begin
				out_valid_q <= 1'b0;
			end
			if (req.restart) begin
				cnt_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.go) begin
						x_q      <= req.x;
						y_q      <= req.y;
						z_q      <= req.z;
						center_q <= center;
						step_q   <= ST_CENTER;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					if (!nbr_ok && (step_q != ST_CENTER)) begin
						shown_q[3'(step_q - 3'd1)] <= shown_dflt;
					end
					if (step_q == ST_POS_X) begin
						state_q <= S_DRAIN;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_DRAIN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (avail == '0) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q   <= 1'b1;
						face_dir_q    <= pick_dir;
						face_x_q      <= x_q;
						face_y_q      <= y_q;
						face_z_q      <= z_q;
						red_out_q     <= red_q;
						green_out_q   <= green_q;
						blue_out_q    <= blue_q;
						base_vertex_q <= {cnt_q, 2'b00};
						index_count_q <= index_next;
						last_face_q   <= last;
						shown_q       <= shown_q & ~pick;
						cnt_q         <= cnt_q + CNT_W'(1);
						if (last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != S_IDLE);
	assign face.valid       = out_valid_q;
	assign face.face_dir    = face_dir_q;
	assign face.face_x      = face_x_q;
	assign face.face_y      = face_y_q;
	assign face.face_z      = face_z_q;
	assign face.red_out     = red_out_q;
	assign face.green_out   = green_out_q;
	assign face.blue_out    = blue_out_q;
	assign face.base_vertex = base_vertex_q;
	assign face.index_count = index_count_q;
	assign face.last_face   = last_face_q;

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !rd_en)
		else $error("store read issued while the sequencer is idle");

	a_go_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> (state_q == S_IDLE))
		else $error("mesh request arrived while the sequencer is busy");

	a_pick_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick))
		else $error("more than one face selected in one cycle");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		load_face |=> (cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1))))
		else $error("face counter did not advance by one on a face load");

endmodule

// ===== design/voxel_face_culling_mesher_unit.sv =====
// Top level of the voxel face culling mesher: command decode, voxel store clearing pass,
// store write path, and the mesh sequencer.
// Depends on vfcm_pkg, vfcm_cmd_if, vfcm_face_if, vfcm_store and vfcm_ctrl.
//
//   Channel   Direction   Carries
//   cmd       in          operation, pos_x/y/z, solid, red_in, green_in, blue_in
//   face      out         face_dir, face_x/y/z, red/green/blue_out, base_vertex,
//                         index_count, last_face
//
// After reset the block sweeps the voxel store once, one entry per cycle, writing every
// entry inactive with colour zero; no command transaction is accepted during the sweep.
// Write and start commands do not make the sequencer busy. After a mesh command
// transaction the sequencer stays busy through seven read steps, one per cycle, for the
// voxel and its six neighbours (a neighbour past the chunk edge is not read), a drain
// state for the last read to land, then emission of one face transaction per cycle while
// the face channel takes them; the emission state is entered even with no exposed face.
// The face output is a register; a stalled face channel holds the sequencer in emission
// but the last face of a command may wait there while the next command is accepted.
module voxel_face_culling_mesher_unit import vfcm_pkg::*; #(
	parameter int unsigned CHUNK_X = 16,
	parameter int unsigned CHUNK_Y = 16,
	parameter int unsigned CHUNK_Z = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	vfcm_cmd_if.sink     cmd,
	vfcm_face_if.source  face
);

	localparam int unsigned DEPTH = CHUNK_X * CHUNK_Y * CHUNK_Z;
	localparam int unsigned AW    = $clog2(DEPTH);

	localparam logic [AW-1:0] ROW_A   = AW'(CHUNK_X);
	localparam logic [AW-1:0] PLANE_A = AW'(CHUNK_X * CHUNK_Y);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic          busy;
	logic          accept;
	logic          in_chunk;
	logic [AW-1:0] vox_addr;
	mesh_req_t     req;

	logic          st_we;
	logic [AW-1:0] st_waddr;
	voxel_t        st_wdata;
	logic          st_re;
	logic [AW-1:0] st_raddr;
	voxel_t        st_rdata;

	// Commands are taken only when the sweep is over and the sequencer is idle.
	assign cmd.ready = !clearing_q && !busy;
	assign accept    = cmd.valid && cmd.ready;

	// Coordinates past the chunk bounds make writes and mesh commands do nothing.
	assign in_chunk = (32'(cmd.pos_x) < CHUNK_X) && (32'(cmd.pos_y) < CHUNK_Y)
		&& (32'(cmd.pos_z) < CHUNK_Z);

	// Linear cell index, x fastest, then y, then z.
	assign vox_addr = AW'(cmd.pos_z) * PLANE_A + AW'(cmd.pos_y) * ROW_A + AW'(cmd.pos_x);

	// The reset sweep walks every store entry once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_A) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// The store write port is shared by the sweep and by voxel write commands.
	always_comb begin
		if (clearing_q) begin
			st_we    = 1'b1;
			st_waddr = clr_addr_q;
			st_wdata = '0;
		end else begin
			st_we          = accept && (cmd.operation == OP_WRITE) && in_chunk;
			st_waddr       = vox_addr;
			st_wdata.active = cmd.solid;
			st_wdata.red    = cmd.red_in;
			st_wdata.green  = cmd.green_in;
			st_wdata.blue   = cmd.blue_in;
		end
	end

	// A start command only clears the face counter; an unused code does nothing.
	assign req.go      = accept && (cmd.operation == OP_MESH) && in_chunk;
	assign req.restart = accept && (cmd.operation == OP_START);
	assign req.x       = cmd.pos_x;
	assign req.y       = cmd.pos_y;
	assign req.z       = cmd.pos_z;

	vfcm_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	vfcm_ctrl #(
		.CHUNK_X (CHUNK_X),
		.CHUNK_Y (CHUNK_Y),
		.CHUNK_Z (CHUNK_Z),
		.AW      (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.center  (vox_addr),
		.busy    (busy),
		.rd_en   (st_re),
		.rd_addr (st_raddr),
		.rd_data (st_rdata),
		.face    (face)
	);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for voxel_face_culling_mesher_unit: drives voxel writes, mesh
// and start commands, and checks every face record against a built-in chunk predictor.
// Depends on vfcm_pkg, vfcm_cmd_if, vfcm_face_if and the design under test.
module tb;
	import vfcm_pkg::*;

	localparam int CHUNK_X = 16;
	localparam int CHUNK_Y = 16;
	localparam int CHUNK_Z = 16;
	localparam int unsigned VERTS_PER_FACE   = 4;
	localparam int unsigned INDICES_PER_FACE = 6;

	// Operation code that the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Emission order of the six faces of a voxel, entry 0 first.
	localparam logic [5:0][2:0] DIR_ORDER = {DIR_POS_X, DIR_NEG_X, DIR_NEG_Y, DIR_POS_Y,
		DIR_POS_Z, DIR_NEG_Z};

	localparam int PHASES       = 4;
	localparam int PHASE_ITEMS  = 86;
	localparam int TAIL_CYCLES  = 60;
	// The limit covers the store sweep after reset and the slowest phases with six faces
	// per mesh and long random stalls on both sides.
	localparam int CYCLE_LIMIT  = 400_000;

	typedef struct {
		logic [1:0] op;
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
		logic       solid;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		bit         hold;
	} voxel_cmd_t;

	typedef struct {
		logic [2:0]  dir;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [3:0]  z;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [16:0] base_vertex;
		logic [17:0] index_count;
		logic        last_face;
	} face_rec_t;

	// Idle and stall rates per phase, in percent.
	int unsigned send_idle_by_phase [PHASES] = '{0, 60, 0, 38};
	int unsigned recv_stall_by_phase[PHASES] = '{0, 0, 60, 38};

	logic clk;
	logic arst_n;

	vfcm_cmd_if  cmd_ch ();
	vfcm_face_if face_ch ();

	voxel_face_culling_mesher_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.face   (face_ch)
	);

	// Commands waiting to be offered; the head is the one on the bus while valid is high.
	voxel_cmd_t  cmds_pending[$];
	// Face records the chunk predictor has produced and the block has not yet delivered.
	face_rec_t   faces_due[$];
	// Shadow of the chunk store and the running face counter.
	voxel_t      voxel_mem [CHUNK_X * CHUNK_Y * CHUNK_Z];
	logic [14:0] face_cnt;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatches;
	int unsigned cycle_cnt;
	// Registered view of "no face is outstanding", so the driver never races the monitor.
	logic        all_due_in;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset is asserted from time zero; every input of the block is known from time zero.
	initial begin
		arst_n             = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.operation   = OP_WRITE;
		cmd_ch.pos_x       = '0;
		cmd_ch.pos_y       = '0;
		cmd_ch.pos_z       = '0;
		cmd_ch.solid       = 1'b0;
		cmd_ch.red_in      = '0;
		cmd_ch.green_in    = '0;
		cmd_ch.blue_in     = '0;
		face_ch.ready      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic bit solid_at(input logic [3:0] x, input logic [3:0] y,
		input logic [3:0] z);
		return voxel_mem[{z, y, x}].active;
	endfunction

	// Applies one accepted command to the shadow chunk and queues the faces it exposes.
	// The -y face on the floor and the +y face under the ceiling are culled; x and z faces
	// on the chunk border stay visible.
	task automatic predict_faces(input voxel_cmd_t c);
		logic [11:0] vox_idx;
		voxel_t      v;
		bit          open_side [6];
		int          n_open;
		int          n_done;
		face_rec_t   f;
		vox_idx = {c.z, c.y, c.x};
		v       = voxel_mem[vox_idx];
		if (c.op == OP_START) begin
			face_cnt = '0;
		end else if (c.op == OP_WRITE) begin
			voxel_mem[vox_idx] = '{active: c.solid, red: c.red, green: c.green,
				blue: c.blue};
		end else if (c.op == OP_MESH && v.active) begin
			open_side[0] = !(c.z > 0 && solid_at(c.x, c.y, c.z - 4'd1));
			open_side[1] = !(int'(c.z) + 1 < CHUNK_Z && solid_at(c.x, c.y, c.z + 4'd1));
			open_side[2] = int'(c.y) + 1 < CHUNK_Y && !solid_at(c.x, c.y + 4'd1, c.z);
			open_side[3] = c.y > 0 && !solid_at(c.x, c.y - 4'd1, c.z);
			open_side[4] = !(c.x > 0 && solid_at(c.x - 4'd1, c.y, c.z));
			open_side[5] = !(int'(c.x) + 1 < CHUNK_X && solid_at(c.x + 4'd1, c.y, c.z));
			n_open = 0;
			foreach (open_side[d]) n_open += int'(open_side[d]);
			n_done = 0;
			for (int d = 0; d < 6; d++) begin
				if (open_side[d]) begin
					n_done++;
					f.dir         = DIR_ORDER[d];
					f.x           = c.x;
					f.y           = c.y;
					f.z           = c.z;
					f.red         = v.red;
					f.green       = v.green;
					f.blue        = v.blue;
					f.base_vertex = 17'(32'(face_cnt) * VERTS_PER_FACE);
					f.index_count = 18'((32'(face_cnt) + 1) * INDICES_PER_FACE);
					f.last_face   = (n_done == n_open);
					faces_due     = {faces_due, f};
					face_cnt      = face_cnt + 15'd1;
				end
			end
		end
	endtask

	function automatic void check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("face %s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Command driver. A command stays on the bus until accepted; a new one is offered only
	// after the previous transaction or an empty cycle. A command marked hold is offered
	// only while the bus is empty and no face is outstanding.
	always @(posedge clk or negedge arst_n) begin
		bit present;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				void'(cmds_pending.pop_front());
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				present = cmds_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct;
				if (present && cmds_pending[0].hold && (cmd_ch.valid || !all_due_in)) begin
					present = 1'b0;
				end
				cmd_ch.valid <= present;
				if (present) begin
					cmd_ch.operation <= cmds_pending[0].op;
					cmd_ch.pos_x     <= cmds_pending[0].x;
					cmd_ch.pos_y     <= cmds_pending[0].y;
					cmd_ch.pos_z     <= cmds_pending[0].z;
					cmd_ch.solid     <= cmds_pending[0].solid;
					cmd_ch.red_in    <= cmds_pending[0].red;
					cmd_ch.green_in  <= cmds_pending[0].green;
					cmd_ch.blue_in   <= cmds_pending[0].blue;
				end
			end
		end
	end

	// Monitor: checks each face transaction against the oldest predicted face, feeds every
	// accepted command to the predictor, and stalls the face channel at random.
	always @(posedge clk or negedge arst_n) begin
		face_rec_t  want;
		voxel_cmd_t seen;
		if (!arst_n) begin
			foreach (voxel_mem[i]) voxel_mem[i] = '0;
			face_cnt       = '0;
			face_ch.ready <= 1'b0;
			all_due_in    <= 1'b1;
		end else begin
			if (face_ch.valid && face_ch.ready) begin
				if (faces_due.size() == 0) begin
					$error("face transaction with none expected: dir %0d at (%0d,%0d,%0d)",
						face_ch.face_dir, face_ch.face_x, face_ch.face_y, face_ch.face_z);
					mismatches++;
				end else begin
					want = faces_due.pop_front();
					check_field("face_dir", want.dir, face_ch.face_dir);
					check_field("face_x", want.x, face_ch.face_x);
					check_field("face_y", want.y, face_ch.face_y);
					check_field("face_z", want.z, face_ch.face_z);
					check_field("red_out", want.red, face_ch.red_out);
					check_field("green_out", want.green, face_ch.green_out);
					check_field("blue_out", want.blue, face_ch.blue_out);
					check_field("base_vertex", want.base_vertex, face_ch.base_vertex);
					check_field("index_count", want.index_count, face_ch.index_count);
					check_field("last_face", want.last_face, face_ch.last_face);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				seen.op    = cmd_ch.operation;
				seen.x     = cmd_ch.pos_x;
				seen.y     = cmd_ch.pos_y;
				seen.z     = cmd_ch.pos_z;
				seen.solid = cmd_ch.solid;
				seen.red   = cmd_ch.red_in;
				seen.green = cmd_ch.green_in;
				seen.blue  = cmd_ch.blue_in;
				seen.hold  = 1'b0;
				predict_faces(seen);
			end
			face_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
			all_due_in    <= faces_due.size() == 0;
		end
	end

	// Watchdog on total run length.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) @(posedge clk) cycle_cnt++;
		$display("tb: done, errors");
		$finish;
	end

	task automatic push_cmd(input logic [1:0] op, input logic [3:0] x, input logic [3:0] y,
		input logic [3:0] z, input logic solid, input logic [7:0] red,
		input logic [7:0] green, input logic [7:0] blue);
		voxel_cmd_t c;
		c = '{op: op, x: x, y: y, z: z, solid: solid, red: red, green: green, blue: blue,
			hold: 1'b0};
		cmds_pending = {cmds_pending, c};
	endtask

	// Coordinates mostly fall in a 4-wide cluster so neighbours are often solid; one in
	// four is anywhere in the chunk.
	function automatic logic [3:0] pick_coord(input logic [3:0] base);
		if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
		return base + 4'($urandom_range(0, 3));
	endfunction

	// Stimulus: a directed opening, then four phases of clustered random traffic with
	// different idle and stall rates. Between phases the sender waits for all faces.
	initial begin
		voxel_cmd_t  c;
		logic [11:0] touched[$];
		logic [3:0]  bx;
		logic [3:0]  by;
		logic [3:0]  bz;
		int unsigned pick;
		int unsigned lo;
		mismatches     = 0;
		send_idle_pct  = send_idle_by_phase[0];
		recv_stall_pct = recv_stall_by_phase[0];

		// Corner voxels at both extremes of the chunk with extreme colour bytes.
		push_cmd(OP_WRITE, 4'd0, 4'd0, 4'd0, 1'b1, 8'hFF, 8'h00, 8'hA5);
		push_cmd(OP_MESH, 4'd0, 4'd0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00);
		push_cmd(OP_WRITE, 4'd15, 4'd15, 4'd15, 1'b1, 8'h00, 8'hFF, 8'h5A);
		push_cmd(OP_MESH, 4'd15, 4'd15, 4'd15, 1'b0, 8'hFF, 8'hFF, 8'hFF);
		// A solid neighbour on +x culls the shared faces of both voxels.
		push_cmd(OP_WRITE, 4'd1, 4'd0, 4'd0, 1'b1, 8'h12, 8'h34, 8'h56);
		push_cmd(OP_MESH, 4'd0, 4'd0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00);
		push_cmd(OP_MESH, 4'd1, 4'd0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00);
		// Start restarts vertex numbering at zero.
		push_cmd(OP_START, 4'd0, 4'd0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00);
		push_cmd(OP_MESH, 4'd15, 4'd15, 4'd15, 1'b0, 8'h00, 8'h00, 8'h00);
		// Mesh of an empty voxel yields nothing.
		push_cmd(OP_MESH, 4'd5, 4'd5, 4'd5, 1'b0, 8'h00, 8'h00, 8'h00);
		// The unused code must not write the store.
		push_cmd(OP_UNUSED, 4'd3, 4'd3, 4'd3, 1'b1, 8'hFF, 8'hFF, 8'hFF);
		push_cmd(OP_MESH, 4'd3, 4'd3, 4'd3, 1'b0, 8'h00, 8'h00, 8'h00);
		// Clearing a voxel hides it and uncovers its neighbour.
		push_cmd(OP_WRITE, 4'd0, 4'd0, 4'd0, 1'b0, 8'h77, 8'h88, 8'h99);
		push_cmd(OP_MESH, 4'd0, 4'd0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00);
		push_cmd(OP_MESH, 4'd1, 4'd0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00);
		// A voxel enclosed on all six sides yields no face.
		push_cmd(OP_WRITE, 4'd8, 4'd8, 4'd8, 1'b1, 8'h80, 8'h40, 8'h20);
		push_cmd(OP_WRITE, 4'd8, 4'd8, 4'd7, 1'b1, 8'h01, 8'h02, 8'h03);
		push_cmd(OP_WRITE, 4'd8, 4'd8, 4'd9, 1'b1, 8'h04, 8'h05, 8'h06);
		push_cmd(OP_WRITE, 4'd8, 4'd9, 4'd8, 1'b1, 8'h07, 8'h08, 8'h09);
		push_cmd(OP_WRITE, 4'd8, 4'd7, 4'd8, 1'b1, 8'h0A, 8'h0B, 8'h0C);
		push_cmd(OP_WRITE, 4'd7, 4'd8, 4'd8, 1'b1, 8'h0D, 8'h0E, 8'h0F);
		push_cmd(OP_WRITE, 4'd9, 4'd8, 4'd8, 1'b1, 8'h10, 8'h11, 8'h12);
		push_cmd(OP_MESH, 4'd8, 4'd8, 4'd8, 1'b0, 8'h00, 8'h00, 8'h00);
		push_cmd(OP_MESH, 4'd8, 4'd9, 4'd8, 1'b0, 8'h00, 8'h00, 8'h00);

		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct  = send_idle_by_phase[p];
			recv_stall_pct = recv_stall_by_phase[p];
			bx = '0;
			by = '0;
			bz = '0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Move the working cluster now and then, favoring the chunk borders.
				if (k % 16 == 0) begin
					case ($urandom_range(0, 2))
						0: begin
							bx = '0;
							by = '0;
							bz = 4'd12;
						end
						1: begin
							bx = 4'd12;
							by = 4'd12;
							bz = '0;
						end
						default: begin
							bx = 4'($urandom_range(0, 12));
							by = 4'($urandom_range(0, 12));
							bz = 4'($urandom_range(0, 12));
						end
					endcase
				end
				c.x     = pick_coord(bx);
				c.y     = pick_coord(by);
				c.z     = pick_coord(bz);
				c.solid = $urandom_range(0, 3) != 0;
				c.red   = 8'($urandom);
				c.green = 8'($urandom);
				c.blue  = 8'($urandom);
				c.hold  = (k == PHASE_ITEMS / 2);
				pick    = $urandom_range(0, 99);
				if (pick < 45) begin
					c.op = OP_WRITE;
					touched = {touched, {c.z, c.y, c.x}};
				end else if (pick < 88) begin
					c.op = OP_MESH;
					// Most meshes aim at a recently written voxel so faces come out often.
					if (touched.size() > 0 && $urandom_range(0, 3) != 0) begin
						lo = touched.size() > 24 ? touched.size() - 24 : 0;
						{c.z, c.y, c.x} = touched[$urandom_range(lo, touched.size() - 1)];
					end
				end else if (pick < 95) begin
					c.op = OP_START;
				end else begin
					c.op = OP_UNUSED;
				end
				cmds_pending = {cmds_pending, c};
			end
			// Let the phase run dry before the rates change.
			@(negedge clk);
			while (cmds_pending.size() != 0 || faces_due.size() != 0) @(negedge clk);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && faces_due.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
